// File: rtl/radio_status_frame_link_watchdog_top_assert.svh
// ----------------------------------------------------------------------------
// radio status frame link watchdog assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef RADIO_STATUS_FRAME_LINK_WATCHDOG_TOP_ASSERT_SVH
`define RADIO_STATUS_FRAME_LINK_WATCHDOG_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RSFLW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RSFLW_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define RSFLW_ASSERT(name, clk, rst_n, prop)
`define RSFLW_ASSERT_MSG(name, clk, rst_n, prop, msg)
`endif

`endif

// File: rtl/rsflw_pkg.sv
// ----------------------------------------------------------------------------
// rsflw_pkg
// shared constants and types of the radio status frame link watchdog
// ----------------------------------------------------------------------------
package rsflw_pkg;

  localparam logic [7:0] HDR_0      = 8'hAA;
  localparam logic [7:0] HDR_1      = 8'h55;
  localparam logic [7:0] HDR_2      = 8'h01;
  localparam logic [7:0] HDR_3      = 8'h02;
  localparam logic [7:0] CHECK_SEED = 8'hFC;
  localparam logic [7:0] LINK_UP    = 8'h02;

  localparam logic [7:0] SILENCE_TIMEOUT_RST = 8'd150;
  localparam logic [7:0] REST_TICKS_RST      = 8'd30;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] WATCH_POWERUP = 2'd0;
  localparam logic [1:0] WATCH_ACTIVE  = 2'd1;
  localparam logic [1:0] WATCH_REST    = 2'd2;

  localparam int unsigned REG_ADDR_W = 3;
  localparam logic REG_SILENCE_TIMEOUT = 1'b0;
  localparam logic REG_REST_TICKS      = 1'b1;

  typedef struct packed {
    logic       ok;
    logic [7:0] strength;
    logic [7:0] link;
  } frame_t;

  typedef struct packed {
    logic [1:0] supervisor_phase;
    logic       frame_ok;
    logic [7:0] link_code;
    logic [7:0] signal_strength;
    logic       connected;
    logic       module_power;
  } result_t;

endpackage

// File: rtl/rsflw_parser.sv
// ----------------------------------------------------------------------------
// rsflw_parser
// status frame parser: header match, strength and link capture, check byte
// ----------------------------------------------------------------------------
`include "radio_status_frame_link_watchdog_top_assert.svh"

module rsflw_parser
  import rsflw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output frame_t     frame_o
);

  localparam logic [2:0] PH_HUNT     = 3'd0;
  localparam logic [2:0] PH_HDR1     = 3'd1;
  localparam logic [2:0] PH_HDR2     = 3'd2;
  localparam logic [2:0] PH_HDR3     = 3'd3;
  localparam logic [2:0] PH_STRENGTH = 3'd4;
  localparam logic [2:0] PH_LINK     = 3'd5;
  localparam logic [2:0] PH_CHECK    = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic [7:0] strength_q, strength_d;
  logic [7:0] link_q, link_d;
  logic       check_ok;

  assign check_ok = (byte_i == (CHECK_SEED ^ strength_q ^ link_q));

  always_comb begin
    phase_d    = phase_q;
    strength_d = strength_q;
    link_d     = link_q;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == HDR_0) phase_d = PH_HDR1;
      end
      PH_HDR1: phase_d = (byte_i == HDR_1) ? PH_HDR2 : PH_HUNT;
      PH_HDR2: phase_d = (byte_i == HDR_2) ? PH_HDR3 : PH_HUNT;
      PH_HDR3: phase_d = (byte_i == HDR_3) ? PH_STRENGTH : PH_HUNT;
      PH_STRENGTH: begin
        strength_d = byte_i;
        phase_d    = PH_LINK;
      end
      PH_LINK: begin
        link_d  = byte_i;
        phase_d = PH_CHECK;
      end
      PH_CHECK: phase_d = PH_HUNT;
      default: phase_d = PH_HUNT;
    endcase
  end

  assign frame_o.ok       = byte_valid_i && (phase_q == PH_CHECK) && check_ok;
  assign frame_o.strength = strength_q;
  assign frame_o.link     = link_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      strength_q <= '0;
      link_q     <= '0;
    end else if (byte_valid_i) begin
      phase_q    <= phase_d;
      strength_q <= strength_d;
      link_q     <= link_d;
    end
  end

  `RSFLW_ASSERT(a_strength_then_link, clk_i, rst_ni,
    byte_valid_i && (phase_q == PH_STRENGTH) |=> phase_q == PH_LINK)
  `RSFLW_ASSERT(a_link_then_check, clk_i, rst_ni,
    byte_valid_i && (phase_q == PH_LINK) |=> phase_q == PH_CHECK)
  `RSFLW_ASSERT_MSG(a_check_returns_hunt, clk_i, rst_ni,
    byte_valid_i && (phase_q == PH_CHECK) |=> phase_q == PH_HUNT,
    "parser did not return to hunting after a check byte")

endmodule

// File: rtl/radio_status_frame_link_watchdog_top.sv
// Radio status frame parser and link watchdog. Every accepted item (a
// received byte or a supervisor tick) produces exactly one result item,
// registered and presented on the master side in the cycle after acceptance.
// One item is accepted per clock; the single output register is the only
// limit, so the slave side stalls only while a result waits and the master
// side is not ready. Configuration is an APB port with silence_timeout at
// byte address 0 and rest_ticks at byte address 4; write it only while idle.
// ----------------------------------------------------------------------------
// radio_status_frame_link_watchdog_top
// frame parser, power supervisor, result register and configuration port
// ----------------------------------------------------------------------------
`include "radio_status_frame_link_watchdog_top_assert.svh"

module radio_status_frame_link_watchdog_top
  import rsflw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // rx_byte[7:0], link_enabled, sys_on
  input  logic [0:0]            s_axis_tuser,  // kind
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata   // module_power, connected,
                                               // signal_strength[7:0], link_code[7:0],
                                               // frame_ok, supervisor_phase[1:0]
);

  logic [7:0] timeout_q, rest_q;
  logic       cfg_wr;
  logic       cfg_idx;

  logic       in_accept;
  logic       kind;
  logic [7:0] rx_byte;
  logic       tick_en;

  frame_t     frame;

  logic [1:0] watch_q, watch_d;
  logic [7:0] silence_q, silence_d;
  logic       power_q, power_d;
  logic       conn_q, conn_d;
  logic [7:0] rep_strength_q, rep_strength_d;
  logic [7:0] rep_link_q, rep_link_d;

  logic       out_valid_q;
  result_t    result_q, result_d;

  // configuration
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {24'd0, (cfg_idx == REG_REST_TICKS) ? rest_q : timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= SILENCE_TIMEOUT_RST;
      rest_q    <= REST_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SILENCE_TIMEOUT: timeout_q <= pwdata[7:0];
        REG_REST_TICKS:      rest_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // input side
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser[0];
  assign rx_byte       = s_axis_tdata[7:0];
  assign tick_en       = s_axis_tdata[8] && s_axis_tdata[9];

  rsflw_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept && (kind == KIND_BYTE)),
    .byte_i       (rx_byte),
    .frame_o      (frame)
  );

  // state update
  always_comb begin
    watch_d        = watch_q;
    silence_d      = silence_q;
    power_d        = power_q;
    conn_d         = conn_q;
    rep_strength_d = rep_strength_q;
    rep_link_d     = rep_link_q;
    if (in_accept) begin
      if (kind == KIND_BYTE) begin
        if (frame.ok) begin
          rep_strength_d = frame.strength;
          rep_link_d     = frame.link;
          conn_d         = (frame.link == LINK_UP);
          silence_d      = '0;
        end
      end else if (tick_en) begin
        case (watch_q)
          WATCH_POWERUP: begin
            power_d    = 1'b1;
            rep_link_d = '0;
            silence_d  = '0;
            conn_d     = 1'b0;
            watch_d    = WATCH_ACTIVE;
          end
          WATCH_ACTIVE: begin
            if (silence_q >= timeout_q) begin
              silence_d = '0;
              power_d   = 1'b0;
              watch_d   = WATCH_REST;
            end else begin
              silence_d = silence_q + 8'd1;
            end
          end
          WATCH_REST: begin
            silence_d = silence_q + 8'd1;
            if (silence_q >= rest_q) watch_d = WATCH_POWERUP;
          end
          default: watch_d = WATCH_POWERUP;
        endcase
      end
    end
  end

  always_comb begin
    result_d.module_power     = power_d;
    result_d.connected        = conn_d;
    result_d.signal_strength  = rep_strength_d;
    result_d.link_code        = rep_link_d;
    result_d.frame_ok         = frame.ok;
    result_d.supervisor_phase = watch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_q        <= WATCH_POWERUP;
      silence_q      <= '0;
      power_q        <= 1'b0;
      conn_q         <= 1'b0;
      rep_strength_q <= '0;
      rep_link_q     <= '0;
    end else begin
      watch_q        <= watch_d;
      silence_q      <= silence_d;
      power_q        <= power_d;
      conn_q         <= conn_d;
      rep_strength_q <= rep_strength_d;
      rep_link_q     <= rep_link_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, result_q};

  `RSFLW_ASSERT_MSG(a_power_matches_phase, clk_i, rst_ni,
    power_q == (watch_q == WATCH_ACTIVE),
    "module power disagrees with supervisor phase")
  `RSFLW_ASSERT(a_connected_link_up, clk_i, rst_ni,
    conn_q |-> rep_link_q == LINK_UP)
  `RSFLW_ASSERT(a_accept_gives_result, clk_i, rst_ni,
    in_accept |=> out_valid_q)
  `RSFLW_ASSERT(a_frame_ok_consistent, clk_i, rst_ni,
    out_valid_q && result_q.frame_ok |->
      result_q.connected == (result_q.link_code == LINK_UP))

endmodule

// File: verif/radio_status_frame_link_watchdog_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_status_frame_link_watchdog_top_tb
// streams serial bytes and supervisor ticks into the watchdog under random
// idling on both sides, predicts every status item from a local copy of the
// parser and supervisor state, and checks each result field by field across
// several timeout and rest settings
// ----------------------------------------------------------------------------
module radio_status_frame_link_watchdog_top_tb;
  import rsflw_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RX_HOLD_CYCLES = 120;

  typedef enum logic [2:0] {
    PARSE_HUNT, PARSE_GOT_AA, PARSE_GOT_55, PARSE_GOT_01,
    PARSE_STRENGTH, PARSE_LINK, PARSE_CHECK
  } parse_state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       link_en;
    logic       sys_on;
  } status_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [REG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // rx_byte[7:0], link_enabled, sys_on
  logic [0:0]  s_axis_tuser  = '0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // module_power, connected, signal_strength[7:0],
                                    // link_code[7:0], frame_ok, supervisor_phase[1:0]

  radio_status_frame_link_watchdog_top i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // local copy of the block state
  logic [7:0]   cfg_timeout = SILENCE_TIMEOUT_RST;
  logic [7:0]   cfg_rest    = REST_TICKS_RST;
  parse_state_e parse_st    = PARSE_HUNT;
  logic [7:0]   held_str    = '0;
  logic [7:0]   held_lnk    = '0;
  logic [7:0]   shown_str   = '0;
  logic [7:0]   shown_lnk   = '0;
  logic         link_up     = 1'b0;
  logic [1:0]   watch_st    = WATCH_POWERUP;
  logic [7:0]   silence     = '0;
  logic         powered     = 1'b0;

  status_item_t item_q[$];
  result_t      status_exp_q[$];
  status_item_t cur_item;
  status_item_t next_item;
  result_t      drv_status;
  result_t      want_status;
  result_t      got_status;

  int unsigned queued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned status_cnt = 0;
  int unsigned err_cnt    = 0;
  int unsigned rx_hold    = 0;
  int unsigned stall_cnt  = 0;

  task automatic predict_status(input status_item_t it, output result_t r);
    logic good;
    good = 1'b0;
    if (it.kind == KIND_BYTE) begin
      case (parse_st)
        PARSE_HUNT: begin
          if (it.rx_byte == HDR_0) parse_st = PARSE_GOT_AA;
        end
        PARSE_GOT_AA: parse_st = (it.rx_byte == HDR_1) ? PARSE_GOT_55 : PARSE_HUNT;
        PARSE_GOT_55: parse_st = (it.rx_byte == HDR_2) ? PARSE_GOT_01 : PARSE_HUNT;
        PARSE_GOT_01: parse_st = (it.rx_byte == HDR_3) ? PARSE_STRENGTH : PARSE_HUNT;
        PARSE_STRENGTH: begin
          held_str = it.rx_byte;
          parse_st = PARSE_LINK;
        end
        PARSE_LINK: begin
          held_lnk = it.rx_byte;
          parse_st = PARSE_CHECK;
        end
        PARSE_CHECK: begin
          if (it.rx_byte == (CHECK_SEED ^ held_str ^ held_lnk)) begin
            shown_str = held_str;
            shown_lnk = held_lnk;
            link_up   = (held_lnk == LINK_UP);
            silence   = '0;
            good      = 1'b1;
          end
          parse_st = PARSE_HUNT;
        end
        default: parse_st = PARSE_HUNT;
      endcase
    end else if (it.link_en && it.sys_on) begin
      case (watch_st)
        WATCH_POWERUP: begin
          powered   = 1'b1;
          shown_lnk = '0;
          silence   = '0;
          link_up   = 1'b0;
          watch_st  = WATCH_ACTIVE;
        end
        WATCH_ACTIVE: begin
          if (silence >= cfg_timeout) begin
            silence  = '0;
            powered  = 1'b0;
            watch_st = WATCH_REST;
          end else begin
            silence = silence + 8'd1;
          end
        end
        WATCH_REST: begin
          if (silence >= cfg_rest) watch_st = WATCH_POWERUP;
          silence = silence + 8'd1;
        end
        default: watch_st = WATCH_POWERUP;
      endcase
    end
    r.module_power     = powered;
    r.connected        = link_up;
    r.signal_strength  = shown_str;
    r.link_code        = shown_lnk;
    r.frame_ok         = good;
    r.supervisor_phase = watch_st;
  endtask

  function automatic void flag_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch on status item %0d, %s: expected 0x%0h, got 0x%0h",
               status_cnt, what, exp_v, act_v);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_status(cur_item, drv_status);
        status_exp_q.push_back(drv_status);
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() != 0 &&
            ((taken_cnt >= 500 && taken_cnt < 750) || $urandom_range(99) >= 34)) begin
          next_item = item_q.pop_front();
          cur_item      <= next_item;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, next_item.sys_on, next_item.link_en, next_item.rx_byte};
          s_axis_tuser  <= next_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_exp_q.size() == 0) begin
          flag_mismatch("unexpected item", 0, 32'(m_axis_tdata));
        end else begin
          want_status = status_exp_q.pop_front();
          got_status  = result_t'(m_axis_tdata[20:0]);
          if (got_status.module_power !== want_status.module_power)
            flag_mismatch("module_power", 32'(want_status.module_power),
                          32'(got_status.module_power));
          if (got_status.connected !== want_status.connected)
            flag_mismatch("connected", 32'(want_status.connected), 32'(got_status.connected));
          if (got_status.signal_strength !== want_status.signal_strength)
            flag_mismatch("signal_strength", 32'(want_status.signal_strength),
                          32'(got_status.signal_strength));
          if (got_status.link_code !== want_status.link_code)
            flag_mismatch("link_code", 32'(want_status.link_code), 32'(got_status.link_code));
          if (got_status.frame_ok !== want_status.frame_ok)
            flag_mismatch("frame_ok", 32'(want_status.frame_ok), 32'(got_status.frame_ok));
          if (got_status.supervisor_phase !== want_status.supervisor_phase)
            flag_mismatch("supervisor_phase", 32'(want_status.supervisor_phase),
                          32'(got_status.supervisor_phase));
          if (m_axis_tdata[23:21] !== 3'b000)
            flag_mismatch("pad bits", 0, 32'(m_axis_tdata[23:21]));
        end
        status_cnt++;
        if (status_cnt == 300 || status_cnt == 900) rx_hold = RX_HOLD_CYCLES;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (status_cnt >= 500 && status_cnt < 750) || $urandom_range(99) >= 34;
      end
    end
  end

  // watchdog on forward progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  task automatic add_item(input logic kind, input logic [7:0] b, input logic en,
                          input logic on);
    status_item_t it;
    it.kind    = kind;
    it.rx_byte = b;
    it.link_en = en;
    it.sys_on  = on;
    item_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_item(KIND_BYTE, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic add_tick(input logic en, input logic on);
    add_item(KIND_TICK, 8'($urandom), en, on);
  endtask

  // corrupt_at above 6 sends a clean frame
  task automatic add_frame(input logic [7:0] str, input logic [7:0] lnk,
                           input int unsigned corrupt_at);
    logic [7:0] seq [7];
    seq = '{HDR_0, HDR_1, HDR_2, HDR_3, str, lnk, CHECK_SEED ^ str ^ lnk};
    if (corrupt_at < 7)
      seq[3'(corrupt_at)] = seq[3'(corrupt_at)] ^ 8'($urandom_range(1, 255));
    foreach (seq[k]) add_byte(seq[k]);
  endtask

  task automatic add_random(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  lnk;
    start = queued_cnt;
    while (queued_cnt - start < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        lnk = ($urandom_range(2) == 0) ? 8'($urandom) : LINK_UP;
        add_frame(8'($urandom), lnk, ($urandom_range(4) == 0) ? $urandom_range(6) : 7);
      end else if (pick < 82) begin
        add_tick($urandom_range(9) != 0, $urandom_range(9) != 0);
      end else begin
        add_byte(($urandom_range(3) == 0) ? HDR_0 : 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (!(taken_cnt == queued_cnt && status_exp_q.size() == 0));
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'({reg_sel, 2'b00});
    pwdata  <= {24'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_SILENCE_TIMEOUT) cfg_timeout = value;
    else cfg_rest = value;
  endtask

  task automatic run_phase(input logic [7:0] timeout, input logic [7:0] rest,
                           input int unsigned n);
    wait_drained();
    apb_write(REG_SILENCE_TIMEOUT, timeout);
    apb_write(REG_REST_TICKS, rest);
    add_random(n);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset settings
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b1);
    add_frame(8'hFF, LINK_UP, 7);
    add_frame(8'h00, 8'hFF, 6);
    add_byte(HDR_0);
    add_byte(HDR_0);
    add_byte(HDR_1);
    add_byte(HDR_0);
    add_byte(HDR_1);
    add_byte(8'h00);
    add_frame(8'h00, 8'h00, 7);
    add_random(150);

    run_phase(8'd1,   8'd0,   200);
    run_phase(8'd0,   8'd255, 150);
    run_phase(8'd255, 8'd254, 300);
    run_phase(8'd3,   8'd1,   200);
    run_phase(8'd20,  8'd8,   300);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (status_exp_q.size() != 0)
      flag_mismatch("items never seen", 0, 32'(status_exp_q.size()));
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rsflw_pkg.sv
rtl/rsflw_parser.sv
rtl/radio_status_frame_link_watchdog_top.sv
verif/radio_status_frame_link_watchdog_top_tb.sv
